// ===== sv/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
package cdq_pkg;

	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 4;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 104;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 2'd0,
		CMD_PUSH_REAR  = 2'd1,
		CMD_POP_FRONT  = 2'd2,
		CMD_POP_REAR   = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} stat_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic capture;
		logic load;
	} cdq_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_read;
		logic out_free;
	} cdq_sts_t;

endpackage

// ===== sv/circular_deque.sv =====
// Top level of the circular deque: controller, datapath and port packing.
//
//  Channel  Dir  Handshake          Contents
//  s_*      in   s_tvalid/s_tready  command in s_tuser, push_value in s_tdata
//  m_*      out  m_tvalid/m_tready  status in m_tuser, popped/front/rear/flags/count in m_tdata
//
// A push, or any refused command, goes from S_IDLE to S_FIN; a pop that leaves elements
// behind passes through S_CAP on the way, as the new end value is read back through the
// slot RAM's registered port. Results wait in an output register, so a stalled m_tready
// holds back the next item by at most one result. Reset empties the deque at
// once; the slot store itself is never cleared.
module circular_deque import cdq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] push_value
	input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [31:0] popped_value, [63:32] front_value,
	                                         // [95:64] rear_value, [96] is_empty,
	                                         // [97] is_full, [101:98] occupancy
	output logic [STAT_W-1:0]     m_tuser    // [1:0] status
);

	cdq_ctl_t ctl;
	cdq_sts_t sts;

	cdq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.sts     (sts),
		.ctl     (ctl)
	);

	cdq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.cmd       (cmd_t'(s_tuser)),
		.push_value(s_tdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_user  (m_tuser)
	);

	// At most one datapath command is issued in any cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.accept, ctl.capture, ctl.load}))
		else $error("more than one datapath command at once");

	// A pop that needs a read-back captures it in the very next cycle.
	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.accept && sts.need_read |=> ctl.capture)
		else $error("read-back capture missed");

	// A result never claims to be both empty and full.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[96] && m_tdata[97]))
		else $error("empty and full together");

	// An empty deque reports zero at both ends.
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[96] |-> (m_tdata[95:32] == '0))
		else $error("end values not zero while empty");

	// The result register only loads when the previous result is gone or leaving.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (!m_tvalid || m_tready))
		else $error("result overwritten before transfer");

endmodule

// ===== sv/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/cdq_ctrl.sv =====
// Controller state machine that sequences one deque operation at a time.
module cdq_ctrl import cdq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  cdq_sts_t sts,
	output cdq_ctl_t ctl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CAP,
		S_FIN
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= sts.need_read ? S_CAP : S_FIN;
					end
				end
				S_CAP: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign ctl.accept  = (state_q == S_IDLE) && in_valid;
	assign ctl.capture = (state_q == S_CAP);
	assign ctl.load    = (state_q == S_FIN) && sts.out_free;

endmodule

// ===== sv/cdq_dp.sv =====
// Datapath: indices, count, cached end values, slot store and result register.
module cdq_dp import cdq_pkg::*; #(
	parameter int DEPTH = 8,
	localparam int IW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cdq_ctl_t              ctl,
	output cdq_sts_t              sts,
	input  cmd_t                  cmd,
	input  logic [VALUE_W-1:0]    push_value,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [STAT_W-1:0]     out_user
);

	logic [IW-1:0]      head_q, tail_q;
	logic [CW-1:0]      count_q;
	logic               out_valid_q;
	logic [VALUE_W-1:0] front_q, rear_q, popped_q;
	stat_t              stat_q;
	logic               rd_front_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [STAT_W-1:0]  out_user_q;

	logic               is_push, is_front, empty, full, last;
	logic [IW-1:0]      head_prev, head_next, tail_prev, tail_next;
	logic               we;
	logic [IW-1:0]      waddr, raddr;
	logic [VALUE_W-1:0] rdata;
	logic               res_empty, res_full;
	logic [VALUE_W-1:0] res_front, res_rear;

	assign is_push  = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
	assign is_front = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_POP_FRONT);
	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(DEPTH));
	assign last     = (count_q == CW'(1));

	assign head_prev = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);
	assign head_next = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
	assign tail_prev = (tail_q == '0) ? IW'(DEPTH - 1) : tail_q - IW'(1);
	assign tail_next = (tail_q == IW'(DEPTH - 1)) ? '0 : tail_q + IW'(1);

	// A pop that leaves elements behind must fetch the new end value from the store.
	assign sts.need_read = !is_push && !empty && !last;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign we    = ctl.accept && is_push && !full;
	assign waddr = empty ? '0 : (is_front ? head_prev : tail_next);
	assign raddr = is_front ? head_next : tail_prev;

	cdq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(push_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.accept) begin
				if (is_push && !full) begin
					count_q <= count_q + CW'(1);
					if (empty) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (is_front) begin
						head_q <= head_prev;
					end else begin
						tail_q <= tail_next;
					end
				end else if (!is_push && !empty) begin
					count_q <= count_q - CW'(1);
					if (last) begin
						head_q <= '0;
						tail_q <= '0;
					end else if (is_front) begin
						head_q <= head_next;
					end else begin
						tail_q <= tail_prev;
					end
				end
			end
			if (ctl.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Cached end values are stale while empty; the result masks them to zero.
	assign res_empty = (count_q == '0);
	assign res_full  = (count_q == CW'(DEPTH));
	assign res_front = res_empty ? '0 : front_q;
	assign res_rear  = res_empty ? '0 : rear_q;

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_front_q <= is_front;
			if (is_push && full) begin
				stat_q <= STAT_FULL;
			end else if (!is_push && empty) begin
				stat_q <= STAT_EMPTY;
			end else begin
				stat_q <= STAT_DONE;
			end
			popped_q <= (!is_push && !empty) ? (is_front ? front_q : rear_q) : '0;
			if (is_push && !full) begin
				if (empty) begin
					front_q <= push_value;
					rear_q  <= push_value;
				end else if (is_front) begin
					front_q <= push_value;
				end else begin
					rear_q <= push_value;
				end
			end
		end
		if (ctl.capture) begin
			if (rd_front_q) begin
				front_q <= rdata;
			end else begin
				rear_q <= rdata;
			end
		end
		if (ctl.load) begin
			out_data_q <= {2'b00, OCC_W'(count_q), res_full, res_empty,
				res_rear, res_front, popped_q};
			out_user_q <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// ===== tb/circular_deque_test.sv =====
// Self-checking testbench for the circular deque: directed and random stream traffic.
module circular_deque_test;
	import cdq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 8;
	localparam int RANDOM_ITEMS = 1350;
	localparam int MAX_WAIT = 16;

	typedef struct {
		cmd_t        cmd;
		logic [31:0] value;
	} deque_op_t;

	typedef struct {
		logic [31:0] popped_value;
		stat_t       status;
		logic [31:0] front_value;
		logic [31:0] rear_value;
		logic        is_empty;
		logic        is_full;
		logic [3:0]  occupancy;
	} deque_view_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] push_value
	logic [CMD_W-1:0]      s_tuser = '0;   // [1:0] command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [31:0] popped, [63:32] front, [95:64] rear,
	                                       // [96] empty, [97] full, [101:98] occupancy
	logic [STAT_W-1:0]     m_tuser;        // [1:0] status

	deque_op_t   pending_ops[$];
	deque_view_t expected_views[$];
	int          failures = 0;

	// Shadow copy of the deque contents.
	logic [31:0] shadow_slots[DEPTH];
	int          shadow_head = 0;
	int          shadow_tail = 0;
	int          shadow_count = 0;

	// Handshake flags sampled at the rising edge, read by the drivers at the falling edge.
	logic s_took = 1'b0;
	logic m_took = 1'b0;
	int   send_gap = 0;
	int   recv_stall = 0;
	logic send_steady = 1'b0;
	logic recv_steady = 1'b0;

	circular_deque #(.DEPTH(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic deque_view_t apply_deque_op(cmd_t cmd, logic [31:0] value);
		deque_view_t view;
		view.popped_value = '0;
		view.status = STAT_DONE;
		if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_REAR) begin
			if (shadow_count >= DEPTH) begin
				view.status = STAT_FULL;
			end else begin
				// The first element always lands in slot zero, whichever end is named.
				if (shadow_count == 0) begin
					shadow_head = 0;
					shadow_tail = 0;
					shadow_slots[0] = value;
				end else if (cmd == CMD_PUSH_FRONT) begin
					shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
					shadow_slots[shadow_head] = value;
				end else begin
					shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
					shadow_slots[shadow_tail] = value;
				end
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				view.status = STAT_EMPTY;
			end else begin
				if (cmd == CMD_POP_FRONT) begin
					view.popped_value = shadow_slots[shadow_head];
					shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
				end else begin
					view.popped_value = shadow_slots[shadow_tail];
					shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
				end
				shadow_count--;
				if (shadow_count == 0) begin
					shadow_head = 0;
					shadow_tail = 0;
				end
			end
		end
		view.is_empty = (shadow_count == 0);
		view.is_full = (shadow_count >= DEPTH);
		view.front_value = view.is_empty ? '0 : shadow_slots[shadow_head];
		view.rear_value = view.is_empty ? '0 : shadow_slots[shadow_tail];
		view.occupancy = shadow_count[3:0];
		return view;
	endfunction

	task automatic queue_op(cmd_t cmd, logic [31:0] value);
		deque_op_t op;
		op.cmd = cmd;
		op.value = value;
		pending_ops.push_back(op);
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, actual %h", name, want, got);
			failures++;
		end
	endtask

	// Sender: one item at a time, with a random gap in front of each.
	always @(negedge clk) begin
		logic next_valid;
		next_valid = s_tvalid;
		if (arst_n) begin
			if (s_took) begin
				next_valid = 1'b0;
				if ($urandom_range(0, 15) == 0)
					send_steady = ~send_steady;
				send_gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_ops.size() > 0) begin
					s_tuser <= pending_ops[0].cmd;
					s_tdata <= pending_ops[0].value;
					void'(pending_ops.pop_front());
					next_valid = 1'b1;
				end
			end
			s_tvalid <= next_valid;
		end
	end

	// Receiver: after each result transfer, stall for a random number of cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_took) begin
				if ($urandom_range(0, 15) == 0)
					recv_steady = ~recv_steady;
				recv_stall = recv_steady ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		deque_view_t want;
		s_took <= s_tvalid && s_tready;
		m_took <= m_tvalid && m_tready;
		if (m_tvalid && m_tready) begin
			if (expected_views.size() == 0) begin
				$error("unexpected result transfer: tdata %h, tuser %h", m_tdata, m_tuser);
				failures++;
			end else begin
				want = expected_views.pop_front();
				compare_field("popped_value", want.popped_value, m_tdata[31:0]);
				compare_field("status", 32'(want.status), 32'(m_tuser));
				compare_field("front_value", want.front_value, m_tdata[63:32]);
				compare_field("rear_value", want.rear_value, m_tdata[95:64]);
				compare_field("is_empty", 32'(want.is_empty), 32'(m_tdata[96]));
				compare_field("is_full", 32'(want.is_full), 32'(m_tdata[97]));
				compare_field("occupancy", 32'(want.occupancy), 32'(m_tdata[101:98]));
			end
		end
		if (s_tvalid && s_tready)
			expected_views.push_back(apply_deque_op(cmd_t'(s_tuser), s_tdata));
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		int push_bias;
		int phase_left;
		cmd_t cmd;
		logic [31:0] value;

		// Refused pops on an empty deque, then the first push at either end.
		queue_op(CMD_POP_FRONT, 32'hdead_beef);
		queue_op(CMD_POP_REAR, 32'h1234_5678);
		queue_op(CMD_PUSH_FRONT, 32'h7fff_ffff);
		queue_op(CMD_POP_REAR, '0);
		queue_op(CMD_PUSH_REAR, 32'h8000_0000);
		queue_op(CMD_PUSH_FRONT, 32'h0000_0000);
		queue_op(CMD_PUSH_REAR, 32'hffff_ffff);
		queue_op(CMD_PUSH_FRONT, 32'ha5a5_a5a5);
		queue_op(CMD_PUSH_REAR, 32'h5a5a_5a5a);
		queue_op(CMD_PUSH_FRONT, 32'h0000_0001);
		queue_op(CMD_PUSH_REAR, 32'hfffe_fffe);
		queue_op(CMD_PUSH_FRONT, 32'h0000_0002);
		// The deque is full now, so both pushes are refused.
		queue_op(CMD_PUSH_FRONT, 32'h1111_1111);
		queue_op(CMD_PUSH_REAR, 32'h2222_2222);
		for (int i = 0; i < DEPTH; i++)
			queue_op((i % 2 == 0) ? CMD_POP_FRONT : CMD_POP_REAR, $urandom());
		queue_op(CMD_POP_FRONT, '0);
		queue_op(CMD_PUSH_REAR, 32'h8000_0001);
		queue_op(CMD_POP_FRONT, '0);

		// Random walk in phases that lean towards filling, draining or neither,
		// so that both the full and the empty boundary are crossed often.
		push_bias = 50;
		phase_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 50);
				case ($urandom_range(0, 2))
					0: push_bias = 85;
					1: push_bias = 50;
					default: push_bias = 15;
				endcase
			end
			phase_left--;
			if ($urandom_range(0, 99) < push_bias)
				cmd = ($urandom_range(0, 1) == 0) ? CMD_PUSH_FRONT : CMD_PUSH_REAR;
			else
				cmd = ($urandom_range(0, 1) == 0) ? CMD_POP_FRONT : CMD_POP_REAR;
			case ($urandom_range(0, 15))
				0: value = 32'h8000_0000;
				1: value = 32'h7fff_ffff;
				2: value = '0;
				3: value = '1;
				default: value = $urandom();
			endcase
			queue_op(cmd, value);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_ops.size() == 0 && !s_tvalid);
		wait (expected_views.size() == 0);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/cdq_pkg.sv
sv/cdq_ram.sv
sv/cdq_ctrl.sv
sv/cdq_dp.sv
sv/circular_deque.sv
tb/circular_deque_test.sv
